// ===== rtl/multilevel_vlc_decoder_assert.svh =====
// Assertion helpers used by the decoder back end, mvlc_back.
// Both expect a clock named clk and a synchronous active-high reset named rst.
`ifndef MULTILEVEL_VLC_DECODER_ASSERT_SVH
`define MULTILEVEL_VLC_DECODER_ASSERT_SVH

// Same-cycle implication.
`define MVLC_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MVLC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mvlc_pkg.sv =====
package mvlc_pkg;

  localparam int TABLE_WORDS_DEFAULT = 4096;
  localparam int QUEUE_DEPTH         = 4;
  localparam int RESULT_CAP          = 64;
  localparam int LEVEL_LIMIT         = 4;
  localparam int ADDR_W              = 12;
  localparam int WORD_W              = 32;
  localparam int BUFFER_W            = 64;
  localparam int LOOKAHEAD_W         = 6;
  localparam int CFG_DATA_W          = 6;

  localparam logic [23:0]            FORBIDDEN_VALUE = 24'h00f0f1;
  localparam logic [LOOKAHEAD_W-1:0] LOOKAHEAD_RESET = 6'd32;
  localparam logic [LOOKAHEAD_W-1:0] MAX_LEVEL_BITS  = 6'd32;

  // Input opcodes.
  localparam logic [1:0] OP_TABLE_WRITE = 2'd0;
  localparam logic [1:0] OP_STREAM      = 2'd1;
  localparam logic [1:0] OP_DRAIN       = 2'd2;
  localparam logic [1:0] OP_RESTART     = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_PAIR_MODE = 1'b0;
  localparam logic CFG_LOOKAHEAD = 1'b1;

  typedef enum logic [1:0] {
    KIND_TABLE_WRITE,
    KIND_STREAM,
    KIND_DRAIN,
    KIND_RESTART
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOP,
    ST_PEEK,
    ST_ADDR,
    ST_ENT,
    ST_CNT,
    ST_CONSUME,
    ST_EMIT
  } state_t;

  typedef struct packed {
    kind_t              kind;
    logic               addr_ok;
    logic [ADDR_W-1:0]  table_address;
    logic [WORD_W-1:0]  data_word;
  } item_t;

  typedef struct packed {
    logic                   pair_mode;
    logic [LOOKAHEAD_W-1:0] lookahead_bits;
  } cfg_t;

endpackage

// ===== rtl/mvlc_in_if.sv =====
interface mvlc_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  opcode;
  logic [mvlc_pkg::ADDR_W-1:0] table_address;
  logic [mvlc_pkg::WORD_W-1:0] data_word;

  modport source(output valid, opcode, table_address, data_word, input ready);
  modport sink(input valid, opcode, table_address, data_word, output ready);
endinterface

// ===== rtl/mvlc_out_if.sv =====
interface mvlc_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] single_value;
  logic signed [7:0]  first_value;
  logic signed [15:0] second_value;
  logic               code_error;
  logic               last_of_run;

  modport source(output valid, single_value, first_value, second_value, code_error,
                 last_of_run, input ready);
  modport sink(input valid, single_value, first_value, second_value, code_error,
               last_of_run, output ready);
endinterface

// ===== rtl/mvlc_front.sv =====
module mvlc_front #(
  parameter int TABLE_WORDS = mvlc_pkg::TABLE_WORDS_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  mvlc_in_if.sink         items,
  output logic            head_valid,
  output mvlc_pkg::item_t head,
  input  logic            pop
);

  localparam int DEPTH  = mvlc_pkg::QUEUE_DEPTH;
  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = $clog2(DEPTH + 1);

  mvlc_pkg::item_t    queue_mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [FILL_W-1:0]  fill;
  mvlc_pkg::item_t    incoming;
  logic               push;
  logic               do_pop;

  always_comb begin
    incoming.table_address = items.table_address;
    incoming.data_word     = items.data_word;
    incoming.addr_ok       = 32'(items.table_address) < 32'(TABLE_WORDS);
    unique case (items.opcode)
      mvlc_pkg::OP_TABLE_WRITE: incoming.kind = mvlc_pkg::KIND_TABLE_WRITE;
      mvlc_pkg::OP_STREAM:      incoming.kind = mvlc_pkg::KIND_STREAM;
      mvlc_pkg::OP_DRAIN:       incoming.kind = mvlc_pkg::KIND_DRAIN;
      mvlc_pkg::OP_RESTART:     incoming.kind = mvlc_pkg::KIND_RESTART;
    endcase
  end

  assign items.ready = fill != FILL_W'(DEPTH);
  assign push        = items.valid && items.ready;
  assign head_valid  = fill != '0;
  assign head        = queue_mem[rd_ptr];
  assign do_pop      = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      queue_mem[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !do_pop) begin
        fill <= fill + FILL_W'(1);
      end else if (do_pop && !push) begin
        fill <= fill - FILL_W'(1);
      end
    end
  end

endmodule

// ===== rtl/mvlc_back.sv =====
`include "multilevel_vlc_decoder_assert.svh"

module mvlc_back #(
  parameter int TABLE_WORDS = mvlc_pkg::TABLE_WORDS_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  mvlc_pkg::cfg_t  cfg,
  input  logic            head_valid,
  input  mvlc_pkg::item_t head,
  output logic            pop,
  mvlc_out_if.source      results
);

  localparam int AW = $clog2(TABLE_WORDS);

  mvlc_pkg::state_t state;
  mvlc_pkg::state_t state_next;

  logic [31:0] code_table [TABLE_WORDS];
  logic [31:0] rdata;
  logic        rd_oob;
  logic        rd_oob_next;
  logic        rd_en;
  logic [AW-1:0] rd_addr;
  logic        wr_en;

  logic [63:0] buffer;
  logic [6:0]  held;
  logic        err_sticky;
  logic [6:0]  count;
  logic [5:0]  need;
  logic [7:0]  p;
  logic [5:0]  n;
  logic [2:0]  levels;
  logic [23:0] base;
  logic [31:0] pos;
  logic [31:0] ent;
  logic        bad;
  logic        out_valid;
  logic        push;

  logic [31:0] word0;
  logic [31:0] ent_word;
  logic [32:0] ent_sum;
  logic        ent_oob;
  logic        base_oob;
  logic        more;
  logic        deep;
  logic        forbidden;
  logic [5:0]  need_cfg;
  logic [63:0] append;
  logic [7:0]  consumed;
  logic [6:0]  cons;
  logic [6:0]  count_inc;
  logic        last;

  function automatic logic [31:0] peek_bits(input logic [63:0] buf_v,
                                            input logic [7:0] pos_v,
                                            input logic [5:0] n_v);
    logic [63:0] shifted;
    logic [6:0]  rsh;
    shifted = buf_v << pos_v[5:0];
    rsh     = 7'd64 - 7'(n_v);
    if (n_v == 6'd0 || pos_v >= 8'd64) begin
      return '0;
    end
    return 32'(shifted >> rsh);
  endfunction

  // A level bit count above the widest peek is taken as the widest peek.
  function automatic logic [5:0] clamp_count(input logic [31:0] w);
    return (w > 32'(mvlc_pkg::MAX_LEVEL_BITS)) ? mvlc_pkg::MAX_LEVEL_BITS : w[5:0];
  endfunction

  always_comb begin
    if (cfg.lookahead_bits == '0) begin
      need_cfg = 6'd1;
    end else if (cfg.lookahead_bits > mvlc_pkg::MAX_LEVEL_BITS) begin
      need_cfg = mvlc_pkg::MAX_LEVEL_BITS;
    end else begin
      need_cfg = cfg.lookahead_bits;
    end
  end

  assign ent_word  = rd_oob ? '0 : rdata;
  assign ent_sum   = 33'(base) + 33'(pos) + 33'd1;
  assign ent_oob   = ent_sum >= 33'(TABLE_WORDS);
  assign base_oob  = 33'(ent_word[31:8]) >= 33'(TABLE_WORDS);
  assign more      = held >= 7'(need) && count < 7'(mvlc_pkg::RESULT_CAP);
  assign deep      = levels >= 3'(mvlc_pkg::LEVEL_LIMIT);
  assign forbidden = ent_word[31:8] == mvlc_pkg::FORBIDDEN_VALUE;
  assign append    = {head.data_word, 32'd0} >> held[5:0];
  assign consumed  = (p > ent[7:0]) ? p - ent[7:0] : 8'd0;
  assign cons      = (consumed > {1'b0, held}) ? held : consumed[6:0];
  assign count_inc = count + 7'd1;
  assign last      = bad || !(held >= 7'(need) && count_inc < 7'(mvlc_pkg::RESULT_CAP));
  assign push      = (state == mvlc_pkg::ST_EMIT) && (!out_valid || results.ready);

  always_comb begin
    state_next = state;
    unique case (state)
      mvlc_pkg::ST_IDLE: begin
        if (head_valid && !err_sticky &&
            (head.kind == mvlc_pkg::KIND_STREAM || head.kind == mvlc_pkg::KIND_DRAIN)) begin
          state_next = mvlc_pkg::ST_LOOP;
        end
      end
      mvlc_pkg::ST_LOOP:    state_next = more ? mvlc_pkg::ST_PEEK : mvlc_pkg::ST_IDLE;
      mvlc_pkg::ST_PEEK:    state_next = mvlc_pkg::ST_ADDR;
      mvlc_pkg::ST_ADDR:    state_next = mvlc_pkg::ST_ENT;
      mvlc_pkg::ST_ENT: begin
        if (ent_word[7]) begin
          state_next = deep ? mvlc_pkg::ST_EMIT : mvlc_pkg::ST_CNT;
        end else begin
          state_next = forbidden ? mvlc_pkg::ST_EMIT : mvlc_pkg::ST_CONSUME;
        end
      end
      mvlc_pkg::ST_CNT:     state_next = mvlc_pkg::ST_PEEK;
      mvlc_pkg::ST_CONSUME: state_next = mvlc_pkg::ST_EMIT;
      mvlc_pkg::ST_EMIT: begin
        if (push) begin
          state_next = bad ? mvlc_pkg::ST_IDLE : mvlc_pkg::ST_LOOP;
        end
      end
      default:              state_next = mvlc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pop         = 1'b0;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = AW'(ent_sum);
    rd_oob_next = rd_oob;
    unique case (state)
      mvlc_pkg::ST_IDLE: begin
        pop   = head_valid;
        wr_en = head_valid && head.kind == mvlc_pkg::KIND_TABLE_WRITE && head.addr_ok;
      end
      mvlc_pkg::ST_ADDR: begin
        rd_en       = !ent_oob;
        rd_oob_next = ent_oob;
      end
      mvlc_pkg::ST_ENT: begin
        // A pointer entry fetches the bit count held in word 0 of its subtable.
        rd_addr = AW'(ent_word[31:8]);
        if (ent_word[7] && !deep) begin
          rd_en       = !base_oob;
          rd_oob_next = base_oob;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      code_table[AW'(head.table_address)] <= head.data_word;
    end
    if (rd_en) begin
      rdata <= code_table[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= mvlc_pkg::ST_IDLE;
      buffer     <= '0;
      held       <= '0;
      err_sticky <= 1'b0;
      count      <= '0;
      bad        <= 1'b0;
      out_valid  <= 1'b0;
      rd_oob     <= 1'b0;
    end else begin
      state  <= state_next;
      rd_oob <= rd_oob_next;
      if (push) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        mvlc_pkg::ST_IDLE: begin
          if (head_valid) begin
            unique case (head.kind)
              mvlc_pkg::KIND_RESTART: begin
                buffer     <= '0;
                held       <= '0;
                err_sticky <= 1'b0;
              end
              mvlc_pkg::KIND_STREAM: begin
                if (!err_sticky) begin
                  // A word that does not fit is dropped.
                  if (held <= 7'd32) begin
                    buffer <= buffer | append;
                    held   <= held + 7'd32;
                  end
                  count <= '0;
                  need  <= need_cfg;
                end
              end
              mvlc_pkg::KIND_DRAIN: begin
                if (!err_sticky) begin
                  count <= '0;
                  need  <= 6'd1;
                end
              end
              default: begin
              end
            endcase
          end
        end
        mvlc_pkg::ST_LOOP: begin
          p      <= '0;
          levels <= 3'd1;
          base   <= '0;
          bad    <= 1'b0;
          n      <= clamp_count(word0);
        end
        mvlc_pkg::ST_PEEK: begin
          pos <= peek_bits(buffer, p, n);
          p   <= p + 8'(n);
        end
        mvlc_pkg::ST_ENT: begin
          ent <= ent_word;
          if (ent_word[7]) begin
            if (deep) begin
              bad <= 1'b1;
            end else begin
              base   <= ent_word[31:8];
              levels <= levels + 3'd1;
            end
          end else begin
            bad <= forbidden;
          end
        end
        mvlc_pkg::ST_CNT: begin
          n <= clamp_count(ent_word);
        end
        mvlc_pkg::ST_CONSUME: begin
          buffer <= (cons >= 7'd64) ? '0 : buffer << cons[5:0];
          held   <= held - cons;
        end
        mvlc_pkg::ST_EMIT: begin
          if (push) begin
            count <= count_inc;
            if (bad) begin
              err_sticky <= 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Word 0 of the table is kept in a register so each codeword starts without a read.
  always_ff @(posedge clk) begin
    if (wr_en && head.table_address == '0) begin
      word0 <= head.data_word;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      results.single_value <= cfg.pair_mode ? 24'sd0 : $signed(ent[31:8]);
      results.first_value  <= cfg.pair_mode ? $signed(ent[15:8]) : 8'sd0;
      results.second_value <= cfg.pair_mode ? $signed(ent[31:16]) : 16'sd0;
      results.code_error   <= bad;
      results.last_of_run  <= last;
    end
  end

  assign results.valid = out_valid;

  `MVLC_ASSERT(a_held_max, 1'b1, held <= 7'd64, "bit buffer holds more than 64 bits")
  `MVLC_ASSERT(a_buffer_clean, held < 7'd64, (buffer << held[5:0]) == 64'd0, "stale bits below held bits")
  `MVLC_ASSERT(a_count_cap, 1'b1, count <= 7'(mvlc_pkg::RESULT_CAP), "result count beyond cap")
  `MVLC_ASSERT(a_err_cause, $rose(err_sticky), $past(state == mvlc_pkg::ST_EMIT && bad), "error set without a bad code")
  `MVLC_ASSERT_NEXT(a_err_holds, err_sticky && !(state == mvlc_pkg::ST_IDLE && head_valid && head.kind == mvlc_pkg::KIND_RESTART), err_sticky, "error cleared without restart")

endmodule

// ===== rtl/multilevel_vlc_decoder.sv =====
// Multilevel table VLC decoder.
// Input channel "items" carries table writes, 32-bit stream words (MSB first),
// end-of-stream drains and restarts. Output channel "results" carries one decoded
// codeword per request; last_of_run marks the final one caused by an input item.
// Both channels use valid/ready; a request moves when both are high.
// Configuration (pair_mode, lookahead_bits) is written through cfg_write, cfg_index
// and cfg_data by the user only while the block is idle; the block does not check it.
// Input items enter a four-entry queue and are executed in order by a sequencer
// that walks the code table held in a single-port RAM with registered read data.
// A table write, restart or ignored item is handled in the idle state alone. Each
// codeword steps through LOOP, PEEK, ADDR, ENT, CONSUME and EMIT (a bad code skips
// CONSUME); each subtable level repeats CNT, PEEK, ADDR and ENT for its table reads.
// Reset clears the queue, the bit buffer, the error flag and the output register,
// and restores pair_mode 0 and lookahead_bits 32; the table is undefined until written.
// When the receiver stalls, the finished result waits in the output register, the
// sequencer holds, and the queue keeps accepting until it is full.
module multilevel_vlc_decoder #(
  parameter int TABLE_WORDS = mvlc_pkg::TABLE_WORDS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  mvlc_in_if.sink                         items,
  mvlc_out_if.source                      results,
  input  logic                            cfg_write,
  input  logic                            cfg_index,
  input  logic [mvlc_pkg::CFG_DATA_W-1:0] cfg_data
);

  mvlc_pkg::cfg_t  cfg;
  logic            head_valid;
  mvlc_pkg::item_t head;
  logic            pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pair_mode      <= 1'b0;
      cfg.lookahead_bits <= mvlc_pkg::LOOKAHEAD_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        mvlc_pkg::CFG_PAIR_MODE: cfg.pair_mode      <= cfg_data[0];
        mvlc_pkg::CFG_LOOKAHEAD: cfg.lookahead_bits <= cfg_data[mvlc_pkg::LOOKAHEAD_W-1:0];
      endcase
    end
  end

  mvlc_front #(
    .TABLE_WORDS(TABLE_WORDS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .items     (items),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop)
  );

  mvlc_back #(
    .TABLE_WORDS(TABLE_WORDS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop),
    .results   (results)
  );

endmodule

// ===== verif/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mvlc_pkg::*;

  localparam int TBL_WORDS      = TABLE_WORDS_DEFAULT;
  localparam int SUB_STRIDE     = 512;
  localparam int SUB_TABLES     = 7;
  localparam int QUIET_CYCLES   = 60;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS    = 25;
  localparam int PHASES         = 6;
  localparam int MAX_REPORTS    = 40;

  // Settings of the random phases, phase 0 in the lowest slot.
  localparam logic [PHASES-1:0] PHASE_PAIR = 6'b010101;
  localparam logic [PHASES-1:0][LOOKAHEAD_W-1:0] PHASE_LOOK =
    {6'd32, 6'd24, 6'd0, 6'd63, 6'd9, 6'd1};

  typedef struct packed {
    logic signed [23:0] single_value;
    logic signed [7:0]  first_value;
    logic signed [15:0] second_value;
    logic               code_error;
    logic               last_of_run;
  } code_result_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] data;
    logic              typed;
    logic [23:0]       value;
    logic              err;
  } stim_row_t;

  localparam int N_ROWS = 29;

  // Table for the directed requests: entry 1 holds the largest value, entry 2 the
  // smallest, entry 3 points to the subtable at 512, entry 4 holds the forbidden code.
  stim_row_t directed_rows [N_ROWS] = '{
    '{OP_TABLE_WRITE, 12'd0,   32'h00000002, 1'b0, 24'h000000, 1'b0},
    '{OP_TABLE_WRITE, 12'd1,   32'h7fffff00, 1'b0, 24'h000000, 1'b0},
    '{OP_TABLE_WRITE, 12'd2,   32'h80000001, 1'b0, 24'h000000, 1'b0},
    '{OP_TABLE_WRITE, 12'd3,   32'h00020080, 1'b0, 24'h000000, 1'b0},
    '{OP_TABLE_WRITE, 12'd4,   32'h00f0f100, 1'b0, 24'h000000, 1'b0},
    '{OP_TABLE_WRITE, 12'd512, 32'h00000001, 1'b0, 24'h000000, 1'b0},
    '{OP_TABLE_WRITE, 12'd513, 32'h00000500, 1'b0, 24'h000000, 1'b0},
    '{OP_TABLE_WRITE, 12'd514, 32'h00100080, 1'b0, 24'h000000, 1'b0},
    '{OP_STREAM,      12'hfff, 32'h00000000, 1'b1, 24'h7fffff, 1'b0},
    '{OP_RESTART,     12'h000, 32'hffffffff, 1'b0, 24'h000000, 1'b0},
    '{OP_STREAM,      12'h000, 32'h40000000, 1'b1, 24'h800000, 1'b0},
    '{OP_RESTART,     12'hfff, 32'h00000000, 1'b0, 24'h000000, 1'b0},
    '{OP_STREAM,      12'h000, 32'hc0000000, 1'b1, 24'h00f0f1, 1'b1},
    '{OP_STREAM,      12'h000, 32'hffffffff, 1'b0, 24'h000000, 1'b0},
    '{OP_DRAIN,       12'h000, 32'h00000000, 1'b0, 24'h000000, 1'b0},
    '{OP_TABLE_WRITE, 12'd4,   32'h00000300, 1'b0, 24'h000000, 1'b0},
    '{OP_RESTART,     12'h000, 32'h00000000, 1'b0, 24'h000000, 1'b0},
    '{OP_STREAM,      12'h000, 32'h94000000, 1'b1, 24'h000005, 1'b0},
    '{OP_DRAIN,       12'h000, 32'h00000000, 1'b0, 24'h000000, 1'b0},
    '{OP_TABLE_WRITE, 12'd512, 32'h00000000, 1'b0, 24'h000000, 1'b0},
    '{OP_TABLE_WRITE, 12'd513, 32'h00020080, 1'b0, 24'h000000, 1'b0},
    '{OP_STREAM,      12'h000, 32'h80000000, 1'b1, 24'h000200, 1'b1},
    '{OP_RESTART,     12'h000, 32'h00000000, 1'b0, 24'h000000, 1'b0},
    '{OP_TABLE_WRITE, 12'd0,   32'h00000000, 1'b0, 24'h000000, 1'b0},
    '{OP_STREAM,      12'h000, 32'h5a5a5a5a, 1'b0, 24'h000000, 1'b0},
    '{OP_STREAM,      12'h000, 32'ha5a5a5a5, 1'b0, 24'h000000, 1'b0},
    '{OP_STREAM,      12'h000, 32'h0f0f0f0f, 1'b0, 24'h000000, 1'b0},
    '{OP_DRAIN,       12'h000, 32'h00000000, 1'b0, 24'h000000, 1'b0},
    '{OP_RESTART,     12'h000, 32'h00000000, 1'b0, 24'h000000, 1'b0}
  };

  logic clk = 1'b0;
  logic rst;
  logic cfg_write;
  logic cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  mvlc_in_if  items_if ();
  mvlc_out_if results_if ();

  multilevel_vlc_decoder u_top (
    .clk       (clk),
    .rst       (rst),
    .items     (items_if),
    .results   (results_if),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Mirror of the decoder state.
  logic [31:0]      code_mem [TBL_WORDS];
  logic [63:0]      stream_bits;
  int unsigned      held;
  bit               err_latched;
  bit               cfg_pair;
  logic [LOOKAHEAD_W-1:0] cfg_look;

  code_result_t pending_codes [$];
  code_result_t want;

  int send_idle_pct;
  int recv_idle_pct;
  int mismatch_count;
  int items_taken;
  int results_seen;
  int code_errors_seen;
  int stall_cycles;

  logic        row_typed;
  logic [23:0] row_value;
  logic        row_err;

  function automatic logic [31:0] table_rd(input logic [63:0] a);
    return (a < TBL_WORDS) ? code_mem[a[ADDR_W-1:0]] : 32'd0;
  endfunction

  function automatic int unsigned level_bits(input logic [31:0] e);
    return (e > 32) ? 32 : e;
  endfunction

  function automatic logic [31:0] peek_bits(input int unsigned p, input int unsigned n);
    logic [63:0] v;
    if (n == 0 || p >= 64) return 32'd0;
    v = stream_bits << p;
    return 32'(v >> (64 - n));
  endfunction

  // Walks the table for one codeword; returns 1 on a forbidden or runaway code.
  function automatic bit decode_codeword(output code_result_t r);
    int unsigned p, n, lv, unused, used;
    logic [31:0] pos, ent;
    logic [63:0] base;
    bit bad;
    p = 0;
    lv = 1;
    bad = 1'b0;
    n = level_bits(table_rd(64'd0));
    pos = peek_bits(p, n);
    p += n;
    ent = table_rd({32'd0, pos} + 64'd1);
    while (ent[7] && !bad) begin
      if (lv >= LEVEL_LIMIT) begin
        bad = 1'b1;
      end else begin
        base = {40'd0, ent[31:8]};
        n = level_bits(table_rd(base));
        pos = peek_bits(p, n);
        p += n;
        ent = table_rd(base + {32'd0, pos} + 64'd1);
        lv++;
      end
    end
    if (ent[31:8] == FORBIDDEN_VALUE) bad = 1'b1;
    r = '0;
    if (cfg_pair) begin
      r.first_value = ent[15:8];
      r.second_value = ent[31:16];
    end else begin
      r.single_value = ent[31:8];
    end
    r.code_error = bad;
    if (!bad) begin
      unused = ent[7:0];
      used = (p > unused) ? p - unused : 0;
      if (used > held) used = held;
      stream_bits = (used >= 64) ? 64'd0 : stream_bits << used;
      held -= used;
    end
    return bad;
  endfunction

  task automatic decode_item(input logic [1:0] op, input logic [ADDR_W-1:0] addr,
                             input logic [WORD_W-1:0] data, input logic typed,
                             input logic [23:0] tvalue, input logic terr);
    code_result_t run_q [$];
    code_result_t r;
    int unsigned need;
    bit bad;
    bad = 1'b0;
    need = (cfg_look == 0) ? 1 : (cfg_look > 32) ? 32 : cfg_look;
    case (op)
      OP_TABLE_WRITE: code_mem[addr] = data;
      OP_RESTART: begin
        stream_bits = 64'd0;
        held = 0;
        err_latched = 1'b0;
      end
      default: begin
        if (!err_latched) begin
          if (op == OP_STREAM) begin
            // A word that does not fit behind the held bits is dropped.
            if (held <= 32) begin
              stream_bits |= {32'd0, data} << (32 - held);
              held += 32;
            end
          end else begin
            need = 1;
          end
          while (held >= need && run_q.size() < RESULT_CAP && !bad) begin
            bad = decode_codeword(r);
            run_q.push_back(r);
          end
          if (bad) err_latched = 1'b1;
          if (run_q.size() > 0) begin
            r = run_q.pop_back();
            r.last_of_run = 1'b1;
            run_q.push_back(r);
          end
        end
      end
    endcase
    if (typed) begin
      r = '0;
      r.single_value = tvalue;
      r.code_error = terr;
      r.last_of_run = 1'b1;
      run_q.delete();
      run_q.push_back(r);
    end
    foreach (run_q[i]) begin
      if (run_q[i].code_error) code_errors_seen++;
      pending_codes.push_back(run_q[i]);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("tb: code %0d, %s: got %h, wanted %h", results_seen, what, got, exp_val);
  endtask

  always @(posedge clk) begin
    if (!rst && items_if.valid && items_if.ready) begin
      items_taken++;
      decode_item(items_if.opcode, items_if.table_address, items_if.data_word,
                  row_typed, row_value, row_err);
    end
  end

  always @(posedge clk) begin
    if (!rst && results_if.valid && results_if.ready) begin
      results_seen++;
      if (pending_codes.size() == 0) begin
        report_mismatch("code with none pending", {8'd0, results_if.single_value}, 32'd0);
      end else begin
        want = pending_codes.pop_front();
        if (results_if.single_value !== want.single_value)
          report_mismatch("single_value", {8'd0, results_if.single_value},
                          {8'd0, want.single_value});
        if (results_if.first_value !== want.first_value)
          report_mismatch("first_value", {24'd0, results_if.first_value},
                          {24'd0, want.first_value});
        if (results_if.second_value !== want.second_value)
          report_mismatch("second_value", {16'd0, results_if.second_value},
                          {16'd0, want.second_value});
        if (results_if.code_error !== want.code_error)
          report_mismatch("code_error", {31'd0, results_if.code_error},
                          {31'd0, want.code_error});
        if (results_if.last_of_run !== want.last_of_run)
          report_mismatch("last_of_run", {31'd0, results_if.last_of_run},
                          {31'd0, want.last_of_run});
      end
    end
  end

  always @(negedge clk) begin
    results_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (items_if.valid && items_if.ready) || (results_if.valid && results_if.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  function automatic logic [31:0] header_word();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return 32'd0;
    if (r < 10) return $urandom_range(255, 33);
    return $urandom_range(8, 1);
  endfunction

  function automatic logic [31:0] entry_word();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 2) return {FORBIDDEN_VALUE, 8'($urandom_range(7))};
    if (r < 15) return {24'(SUB_STRIDE * $urandom_range(SUB_TABLES, 1)), 8'h80 | 8'($urandom)};
    // Subtable pointer that leaves the table.
    if (r < 19) return {24'($urandom_range(24'hffffff, TBL_WORDS)), 8'h80};
    if (r < 35) return {24'($urandom), 1'b0, 7'($urandom)};
    return {24'($urandom), 8'($urandom_range(4))};
  endfunction

  function automatic logic [31:0] word_for(input logic [ADDR_W-1:0] a);
    return (a % SUB_STRIDE == 0) ? header_word() : entry_word();
  endfunction

  function automatic logic [31:0] stream_word();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return 32'd0;
    if (r < 10) return 32'hffffffff;
    return $urandom;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance, valid still high.
  task automatic send_item(input logic [1:0] op, input logic [ADDR_W-1:0] a,
                           input logic [WORD_W-1:0] d, input logic typed,
                           input logic [23:0] tvalue, input logic terr);
    if ($urandom_range(99) < send_idle_pct) begin
      items_if.valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    items_if.valid <= 1'b1;
    items_if.opcode <= op;
    items_if.table_address <= a;
    items_if.data_word <= d;
    row_typed = typed;
    row_value = tvalue;
    row_err = terr;
    do @(posedge clk); while (!items_if.ready);
    @(negedge clk);
  endtask

  task automatic wait_for_drain();
    items_if.valid <= 1'b0;
    while (pending_codes.size() != 0) @(negedge clk);
    // Requests that decode nothing may still be in the queue behind the last code.
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  task automatic write_settings(input bit pair, input logic [LOOKAHEAD_W-1:0] look);
    cfg_write <= 1'b1;
    cfg_index <= CFG_PAIR_MODE;
    cfg_data <= {5'($urandom), pair};
    @(negedge clk);
    cfg_index <= CFG_LOOKAHEAD;
    cfg_data <= look;
    @(negedge clk);
    cfg_write <= 1'b0;
    cfg_pair = pair;
    cfg_look = look;
  endtask

  task automatic run_random_phase();
    int counted;
    int unsigned r;
    logic [1:0] op;
    logic [ADDR_W-1:0] a;
    logic [WORD_W-1:0] d;
    counted = 0;
    // Fresh level bit counts so each phase decodes with a new table shape.
    send_item(OP_TABLE_WRITE, '0, header_word(), 1'b0, '0, 1'b0);
    for (int k = 1; k <= SUB_TABLES; k++)
      send_item(OP_TABLE_WRITE, ADDR_W'(k * SUB_STRIDE), header_word(), 1'b0, '0, 1'b0);
    while (counted < PHASE_ITEMS) begin
      r = $urandom_range(99);
      a = ADDR_W'($urandom);
      d = $urandom;
      if (err_latched && r < 50) begin
        op = OP_RESTART;
      end else if (r < 62) begin
        op = OP_STREAM;
        d = stream_word();
      end else if (r < 72) begin
        op = OP_DRAIN;
      end else if (r < 78) begin
        op = OP_RESTART;
      end else begin
        op = OP_TABLE_WRITE;
        if ($urandom_range(99) < 30) a = ADDR_W'(SUB_STRIDE * $urandom_range(SUB_TABLES, 0));
        d = word_for(a);
      end
      if (!(err_latched && (op == OP_STREAM || op == OP_DRAIN))) counted++;
      send_item(op, a, d, 1'b0, '0, 1'b0);
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = CFG_PAIR_MODE;
    cfg_data = '0;
    items_if.valid = 1'b0;
    items_if.opcode = OP_TABLE_WRITE;
    items_if.table_address = '0;
    items_if.data_word = '0;
    results_if.ready = 1'b0;
    row_typed = 1'b0;
    row_value = '0;
    row_err = 1'b0;
    send_idle_pct = 37;
    recv_idle_pct = 45;
    mismatch_count = 0;
    items_taken = 0;
    results_seen = 0;
    code_errors_seen = 0;
    stall_cycles = 0;
    stream_bits = 64'd0;
    held = 0;
    err_latched = 1'b0;
    cfg_pair = 1'b0;
    cfg_look = LOOKAHEAD_RESET;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    write_settings(1'b0, 6'd32);

    // Every table word gets a value first, so no lookup ever reads an unwritten entry.
    for (int i = 0; i < TBL_WORDS; i++)
      send_item(OP_TABLE_WRITE, ADDR_W'(i), word_for(ADDR_W'(i)), 1'b0, '0, 1'b0);
    foreach (directed_rows[i])
      send_item(directed_rows[i].op, directed_rows[i].addr, directed_rows[i].data,
                directed_rows[i].typed, directed_rows[i].value, directed_rows[i].err);
    wait_for_drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 2) begin
        send_idle_pct = 45;
        recv_idle_pct = 37;
      end
      if (ph == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_settings(PHASE_PAIR[ph], PHASE_LOOK[ph]);
      run_random_phase();
      wait_for_drain();
    end

    $display("tb: %0d requests taken, %0d codes checked, %0d of them flagged as bad codes",
             items_taken, results_seen, code_errors_seen);
    $display("tb: single and pair mode, lookahead 0 to 63, with and without idle cycles");
    if (mismatch_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/mvlc_pkg.sv
rtl/mvlc_in_if.sv
rtl/mvlc_out_if.sv
rtl/mvlc_front.sv
rtl/mvlc_back.sv
rtl/multilevel_vlc_decoder.sv
verif/tb.sv
